FILE: rtl/core/cppm_frame_generator_defines.svh
// Assertion macros used by the checker file of the frame generator.
`ifndef CPPM_FRAME_GENERATOR_DEFINES_SVH
`define CPPM_FRAME_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CPPM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cppm check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CPPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cppm check failed");

`endif

FILE: rtl/core/cppm_pkg.sv
`timescale 1ns / 1ps

package cppm_pkg;

   localparam int CD_W      = 20;
   localparam int US_W      = 16;
   localparam int WIDTH_W   = 12;
   localparam int NCH_W     = 5;
   localparam int TPU_W     = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [CD_W-1:0]    CD_RESET       = 20'd100;
   localparam logic [WIDTH_W-1:0] PULSE_RESET    = 12'd300;
   localparam logic [US_W-1:0]    FRAME_RESET    = 16'd22500;
   localparam logic [NCH_W-1:0]   CHANNELS_RESET = 5'd11;
   localparam logic [TPU_W-1:0]   TPU_RESET      = 5'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE          = 3'd0,
      CSR_PULSE_LENGTH    = 3'd1,
      CSR_FRAME_LENGTH    = 3'd2,
      CSR_CHANNELS_IN_USE = 3'd3,
      CSR_TICKS_PER_UNIT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic               enable;
      logic [WIDTH_W-1:0] pulse_length;
      logic [US_W-1:0]    frame_length;
      logic [NCH_W-1:0]   channels_in_use;
      logic [TPU_W-1:0]   ticks_per_unit;
   } cfg_type;

   // Timing state of the pulse train; sync marks the expiry that opened the sync gap.
   typedef struct packed {
      logic             pin;
      logic             phase_high;
      logic             sync;
      logic [NCH_W-1:0] next_channel;
      logic [US_W-1:0]  frame_sum;
      logic [CD_W-1:0]  countdown;
   } timing_type;

endpackage

FILE: rtl/core/cppm_if.sv
`timescale 1ns / 1ps

interface cppm_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [3:0]  channel_index;
   logic [11:0] channel_value;

   modport source (output valid, operation, channel_index, channel_value, input ready);
   modport sink   (input valid, operation, channel_index, channel_value, output ready);
endinterface

interface cppm_rsp_if;
   logic       valid;
   logic       ready;
   logic       pin_level;
   logic       sync_start;
   logic [4:0] current_channel;

   modport source (output valid, pin_level, sync_start, current_channel, input ready);
   modport sink   (input valid, pin_level, sync_start, current_channel, output ready);
endinterface

interface cppm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/cppm_frame_generator.sv
`timescale 1ns / 1ps
// An accepted item is held in the input register and moves into the result register when the
// result register is empty or being drained; its result is offered from the result register.
// Throughput: one item per cycle unless the result side stalls; the timing update is a single
// pass through one 16 x 5 bit multiplier and a few subtracts between the input and result registers.
// Reset: synchronous, active high; resets the timing state, clears the channel valid bits and the
// valid flags of both pipeline registers, and loads the configuration defaults. No clearing pass.

module cppm_frame_generator
   import cppm_pkg::*;
#(
   parameter int MAX_CHANNELS = 16
) (
   input logic        clock,
   input logic        reset,
   cppm_req_if.sink   req_ch,
   cppm_rsp_if.source rsp_ch,
   cppm_csr_if.sink   csr_ch
);

   // Width of an index into the channel store.
   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic        in_op_ff;
   logic [3:0]  in_idx_ff;
   logic [11:0] in_val_ff;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pin_ff;
   logic             rsp_sync_ff;
   logic [NCH_W-1:0] rsp_channel_ff;

   // Channel store: entries that were never written since reset read as zero.
   logic [WIDTH_W-1:0]    store_ff [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] store_valid_ff, store_valid_in;

   cfg_type    cfg_ff, cfg_in;
   timing_type state_ff, state_in;
   timing_type cur_timing;
   timing_type exp_timing;

   logic             advance;
   logic             write_hit;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   logic [WIDTH_W-1:0] rd_word;
   logic             tick;
   logic [CD_W-1:0]  cd_dec;
   logic             expire;

   // The input register moves into the result register whenever the result
   // register is empty or being drained in the same cycle.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.pin_level       = rsp_pin_ff;
   assign rsp_ch.sync_start      = rsp_sync_ff;
   assign rsp_ch.current_channel = rsp_channel_ff;

   // Store access: a write to a slot past the store is dropped.
   assign write_hit = advance && in_op_ff && (6'(in_idx_ff) < 6'(MAX_CHANNELS));
   assign wr_idx    = IDX_W'(in_idx_ff);
   assign rd_idx    = state_ff.next_channel[IDX_W-1:0];
   assign rd_word   = store_valid_ff[rd_idx] ? store_ff[rd_idx] : '0;

   // A tick only counts while the output is enabled. The countdown stops at
   // zero, so a zero-length interval expires on the next tick.
   assign tick   = advance && !in_op_ff && cfg_ff.enable;
   assign cd_dec = (state_ff.countdown != '0) ? state_ff.countdown - CD_W'(1) : '0;
   assign expire = tick && (cd_dec == '0);

   always_comb begin
      cur_timing           = state_ff;
      cur_timing.sync      = 1'b0;
      cur_timing.countdown = cd_dec;
   end

   cppm_expire #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_cppm_expire (
      .cur   (cur_timing),
      .cfg   (cfg_ff),
      .width (rd_word),
      .nxt   (exp_timing)
   );

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in.sync = 1'b0;
      end
      if (expire) begin
         state_in = exp_timing;
      end else if (tick) begin
         state_in.countdown = cd_dec;
      end
   end

   always_comb begin
      store_valid_in = store_valid_ff;
      if (write_hit) begin
         store_valid_in[wr_idx] = 1'b1;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration decode; writes to indexes past the register list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_ENABLE:          cfg_in.enable          = csr_ch.data[0];
            CSR_PULSE_LENGTH:    cfg_in.pulse_length    = csr_ch.data[WIDTH_W-1:0];
            CSR_FRAME_LENGTH:    cfg_in.frame_length    = csr_ch.data[US_W-1:0];
            CSR_CHANNELS_IN_USE: cfg_in.channels_in_use = csr_ch.data[NCH_W-1:0];
            CSR_TICKS_PER_UNIT:  cfg_in.ticks_per_unit  = csr_ch.data[TPU_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         store_valid_ff          <= '0;
         state_ff.pin            <= 1'b0;
         state_ff.phase_high     <= 1'b1;
         state_ff.sync           <= 1'b0;
         state_ff.next_channel   <= '0;
         state_ff.frame_sum      <= '0;
         state_ff.countdown      <= CD_RESET;
         cfg_ff.enable           <= 1'b0;
         cfg_ff.pulse_length     <= PULSE_RESET;
         cfg_ff.frame_length     <= FRAME_RESET;
         cfg_ff.channels_in_use  <= CHANNELS_RESET;
         cfg_ff.ticks_per_unit   <= TPU_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         store_valid_ff <= store_valid_in;
         state_ff       <= state_in;
         cfg_ff         <= cfg_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_op_ff  <= req_ch.operation;
         in_idx_ff <= req_ch.channel_index;
         in_val_ff <= req_ch.channel_value;
      end
      if (advance) begin
         rsp_pin_ff     <= state_in.pin;
         rsp_sync_ff    <= state_in.sync;
         rsp_channel_ff <= state_in.next_channel;
      end
      if (write_hit) begin
         store_ff[wr_idx] <= in_val_ff;
      end
   end

endmodule

FILE: rtl/core/cppm_expire.sv
`timescale 1ns / 1ps

module cppm_expire
   import cppm_pkg::*;
#(
   parameter int MAX_CHANNELS = 16
) (
   input  timing_type         cur,
   input  cfg_type            cfg,
   input  logic [WIDTH_W-1:0] width,
   output timing_type         nxt
);

   logic             ciu_over;
   logic [NCH_W-1:0] count;
   logic [US_W:0]    gap_sum;
   logic [US_W:0]    width_sum;
   logic [US_W-1:0]  interval_us;
   logic [CD_W:0]    scaled;

   always_comb begin
      ciu_over  = 6'(cfg.channels_in_use) > 6'(MAX_CHANNELS);
      count     = ciu_over ? NCH_W'(MAX_CHANNELS) : cfg.channels_in_use;
      gap_sum   = (US_W+1)'(cur.frame_sum) + (US_W+1)'(cfg.pulse_length);
      width_sum = (US_W+1)'(cur.frame_sum) + (US_W+1)'(width);
      nxt       = cur;
      nxt.sync  = 1'b0;
      if (cur.phase_high) begin
         // Start of the low separator pulse.
         nxt.pin        = 1'b0;
         nxt.phase_high = 1'b0;
         interval_us    = US_W'(cfg.pulse_length);
      end else begin
         nxt.pin        = 1'b1;
         nxt.phase_high = 1'b1;
         if (cur.next_channel >= count) begin
            // All channels sent: the high phase is the sync gap.
            nxt.next_channel = '0;
            nxt.frame_sum    = '0;
            nxt.sync         = 1'b1;
            interval_us = ((US_W+1)'(cfg.frame_length) > gap_sum) ?
                          US_W'((US_W+1)'(cfg.frame_length) - gap_sum) : '0;
         end else begin
            interval_us = (width > cfg.pulse_length) ?
                          US_W'(width - cfg.pulse_length) : '0;
            nxt.frame_sum    = width_sum[US_W] ? '1 : width_sum[US_W-1:0];
            nxt.next_channel = cur.next_channel + NCH_W'(1);
         end
      end
      scaled        = (CD_W+1)'(interval_us) * (CD_W+1)'(cfg.ticks_per_unit);
      nxt.countdown = scaled[CD_W] ? '1 : scaled[CD_W-1:0];
   end

endmodule

FILE: rtl/core/cppm_checker.sv
`timescale 1ns / 1ps
`include "cppm_frame_generator_defines.svh"

module cppm_checker #(
   parameter int MAX_CHANNELS = 16
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       pin_level,
   input logic       sync_start,
   input logic [4:0] current_channel
);

   // The sync gap is a high phase and restarts the channel sequence.
   `CPPM_ASSERT_IMPL(a_sync_shape, clock, reset, rsp_valid && sync_start, pin_level && (current_channel == 5'd0))

   // The channel pointer never exceeds MAX_CHANNELS.
   `CPPM_ASSERT_IMPL(a_channel_bound, clock, reset, rsp_valid, 6'(current_channel) <= 6'(MAX_CHANNELS))

   // A stalled result holds.
   `CPPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(pin_level) && $stable(sync_start) && $stable(current_channel))

   // Reset empties the result register.
   `CPPM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind cppm_frame_generator cppm_checker #(
   .MAX_CHANNELS (MAX_CHANNELS)
) u_cppm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .pin_level       (rsp_ch.pin_level),
   .sync_start      (rsp_ch.sync_start),
   .current_channel (rsp_ch.current_channel)
);
